### rtl/eeg_pkg.sv
package eeg_pkg;

  // Default operand width.
  localparam int EEG_WIDTH = 32;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } eeg_state_t;

  // Status that the division unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } eeg_div_stat_t;

endpackage

### rtl/eeg_div_unit.sv
// Shared division unit: restoring division, one quotient bit per cycle, MSB first.
// Each quotient bit also feeds a Horner accumulation of quotient * coefficient
// for both coefficient chains, so that the products are ready with the remainder.
module eeg_div_unit #(
  parameter int WIDTH = eeg_pkg::EEG_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WIDTH-1:0]      dividend,
  input  logic [WIDTH-1:0]      dvsr,
  input  logic [WIDTH:0]        mul_s,
  input  logic [WIDTH:0]        mul_t,
  output eeg_pkg::eeg_div_stat_t stat,
  output logic [WIDTH-1:0]      remainder,
  output logic [WIDTH:0]        prod_s,
  output logic [WIDTH:0]        prod_t
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] num_r, num_nxt;
  logic [WIDTH-1:0] den_r, den_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH:0]   ms_r, ms_nxt;
  logic [WIDTH:0]   mt_r, mt_nxt;
  logic [WIDTH:0]   ps_r, ps_nxt;
  logic [WIDTH:0]   pt_r, pt_nxt;

  logic [WIDTH:0]   shifted;
  logic             q_bit;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign shifted = {rem_r, num_r[WIDTH-1]};
  assign q_bit   = (shifted >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    ms_nxt   = ms_r;
    mt_nxt   = mt_r;
    ps_nxt   = ps_r;
    pt_nxt   = pt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH - 1);
      num_nxt  = dividend;
      den_nxt  = dvsr;
      rem_nxt  = '0;
      ms_nxt   = mul_s;
      mt_nxt   = mul_t;
      ps_nxt   = '0;
      pt_nxt   = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[WIDTH-2:0], 1'b0};
      if (q_bit) begin
        rem_nxt = WIDTH'(shifted - {1'b0, den_r});
      end else begin
        rem_nxt = shifted[WIDTH-1:0];
      end
      // Horner form: product = 2 * product + bit * coefficient, modulo 2^(WIDTH+1).
      ps_nxt = {ps_r[WIDTH-1:0], 1'b0} + (q_bit ? ms_r : '0);
      pt_nxt = {pt_r[WIDTH-1:0], 1'b0} + (q_bit ? mt_r : '0);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    ms_r  <= ms_nxt;
    mt_r  <= mt_nxt;
    ps_r  <= ps_nxt;
    pt_r  <= pt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;
  assign prod_s    = ps_r;
  assign prod_t    = pt_r;

endmodule

### rtl/extended_euclidean_gcd.sv
// Extended Euclidean gcd with Bezout coefficients.
// Input channel in_*: a request carries operand_a and operand_b, each WIDTH bits.
// Output channel out_*: one result per request with coeff_s, coeff_t (WIDTH+1 bits,
// two's complement) and divisor, so that a*coeff_s + b*coeff_t = divisor.
// in_tready is high only while the sequencer is idle; the block works on one
// request at a time. Each Euclid step runs one division on the shared
// bit-serial divider, which resolves one quotient bit per cycle. The number of
// Euclid steps is at most about 1.5*WIDTH. When b is zero no division runs:
// the sequencer passes from ST_CHECK straight to ST_DONE, which loads the
// output register.
// A finished result sits in the output register until it is taken, and the next
// request is accepted meanwhile; if that request finishes while the receiver still
// stalls, the sequencer holds its result until the output register frees up.
// Synchronous active-low reset empties the output register and returns the
// sequencer to idle.
module extended_euclidean_gcd #(
  parameter int WIDTH = eeg_pkg::EEG_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0 up: operand_a, operand_b, zero padding.
  input  logic [((2*WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0 up: coeff_s, coeff_t, divisor, zero padding.
  output logic [((3*WIDTH+2+7)/8)*8-1:0]     out_tdata
);

  localparam int OUT_TDATA_W = ((3*WIDTH+2+7)/8)*8;

  eeg_pkg::eeg_state_t    state_r, state_nxt;
  eeg_pkg::eeg_div_stat_t div_stat;

  logic [WIDTH-1:0] rem_hi_r, rem_hi_nxt;
  logic [WIDTH-1:0] rem_lo_r, rem_lo_nxt;
  logic [WIDTH:0]   sa_r, sa_nxt;
  logic [WIDTH:0]   sb_r, sb_nxt;
  logic [WIDTH:0]   ta_r, ta_nxt;
  logic [WIDTH:0]   tb_r, tb_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH:0]   out_s_r, out_s_nxt;
  logic [WIDTH:0]   out_t_r, out_t_nxt;
  logic [WIDTH-1:0] out_d_r, out_d_nxt;

  logic             div_start;
  logic             out_free;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH:0]   div_ps;
  logic [WIDTH:0]   div_pt;

  eeg_div_unit #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_hi_r),
    .dvsr     (rem_lo_r),
    .mul_s    (sb_r),
    .mul_t    (tb_r),
    .stat     (div_stat),
    .remainder(div_rem),
    .prod_s   (div_ps),
    .prod_t   (div_pt)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == eeg_pkg::ST_IDLE);

  // Sequencer: load operands, run division steps until the low remainder is zero, then output the result.
  always_comb begin
    state_nxt     = state_r;
    rem_hi_nxt    = rem_hi_r;
    rem_lo_nxt    = rem_lo_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    out_valid_nxt = out_valid_r;
    out_s_nxt     = out_s_r;
    out_t_nxt     = out_t_r;
    out_d_nxt     = out_d_r;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      eeg_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          rem_hi_nxt = in_tdata[WIDTH-1:0];
          rem_lo_nxt = in_tdata[2*WIDTH-1:WIDTH];
          sa_nxt     = (WIDTH+1)'(1);
          sb_nxt     = '0;
          ta_nxt     = '0;
          tb_nxt     = (WIDTH+1)'(1);
          state_nxt  = eeg_pkg::ST_CHECK;
        end
      end
      eeg_pkg::ST_CHECK: begin
        if (rem_lo_r == '0) begin
          state_nxt = eeg_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = eeg_pkg::ST_DIV;
        end
      end
      eeg_pkg::ST_DIV: begin
        // Shift the remainder and coefficient pairs once the quotient is known.
        if (div_stat.done) begin
          rem_hi_nxt = rem_lo_r;
          rem_lo_nxt = div_rem;
          sa_nxt     = sb_r;
          sb_nxt     = sa_r - div_ps;
          ta_nxt     = tb_r;
          tb_nxt     = ta_r - div_pt;
          state_nxt  = eeg_pkg::ST_CHECK;
        end
      end
      eeg_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_s_nxt     = sa_r;
          out_t_nxt     = ta_r;
          out_d_nxt     = rem_hi_r;
          state_nxt     = eeg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = eeg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eeg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_hi_r <= rem_hi_nxt;
    rem_lo_r <= rem_lo_nxt;
    sa_r     <= sa_nxt;
    sb_r     <= sb_nxt;
    ta_r     <= ta_nxt;
    tb_r     <= tb_nxt;
    out_s_r  <= out_s_nxt;
    out_t_r  <= out_t_nxt;
    out_d_r  <= out_d_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_d_r, out_t_r, out_s_r});

endmodule
